>>> hdl/c8_pkg.sv
`timescale 1ns / 1ps
package c8_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int FRAME_W   = 64;
  localparam int FRAME_H   = 32;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int FR_AW     = $clog2(FRAME_W * FRAME_H);

  localparam logic [11:0] RESET_START = 12'h200;
  localparam logic [11:0] FONT_BASE   = 12'h050;
  localparam logic [11:0] FONT_END    = 12'h09F;

  localparam logic [7:0] FONT_ROM [80] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [1:0] {
    ITEM_WRITE = 2'd0,
    ITEM_EXEC  = 2'd1,
    ITEM_TICK  = 2'd2,
    ITEM_READ  = 2'd3
  } item_op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OVF   = 2'd1,
    STAT_UNF   = 2'd2,
    STAT_BADOP = 2'd3
  } status_t;

  // instruction groups (top nibble)
  localparam logic [3:0] OPG_SYS  = 4'h0;
  localparam logic [3:0] OPG_JP   = 4'h1;
  localparam logic [3:0] OPG_CALL = 4'h2;
  localparam logic [3:0] OPG_SE   = 4'h3;
  localparam logic [3:0] OPG_SNE  = 4'h4;
  localparam logic [3:0] OPG_SEV  = 4'h5;
  localparam logic [3:0] OPG_LD   = 4'h6;
  localparam logic [3:0] OPG_ADD  = 4'h7;
  localparam logic [3:0] OPG_ALU  = 4'h8;
  localparam logic [3:0] OPG_SNEV = 4'h9;
  localparam logic [3:0] OPG_LDI  = 4'hA;
  localparam logic [3:0] OPG_JPV  = 4'hB;
  localparam logic [3:0] OPG_RND  = 4'hC;
  localparam logic [3:0] OPG_DRW  = 4'hD;
  localparam logic [3:0] OPG_KEY  = 4'hE;
  localparam logic [3:0] OPG_MISC = 4'hF;

  localparam logic [11:0] SYS_CLS = 12'h0E0;
  localparam logic [11:0] SYS_RET = 12'h0EE;
  localparam logic [7:0]  KEY_SKP  = 8'h9E;
  localparam logic [7:0]  KEY_SKNP = 8'hA1;
  localparam logic [7:0]  FX_LDDT  = 8'h07;
  localparam logic [7:0]  FX_WAITK = 8'h0A;
  localparam logic [7:0]  FX_SETDT = 8'h15;
  localparam logic [7:0]  FX_SETST = 8'h18;
  localparam logic [7:0]  FX_ADDI  = 8'h1E;
  localparam logic [7:0]  FX_FONT  = 8'h29;
  localparam logic [7:0]  FX_BCD   = 8'h33;
  localparam logic [7:0]  FX_STORE = 8'h55;
  localparam logic [7:0]  FX_LOAD  = 8'h65;

  // encodings match the low nibble of 8xyN
  typedef enum logic [3:0] {
    ALU_PASSB = 4'h0,
    ALU_OR    = 4'h1,
    ALU_AND   = 4'h2,
    ALU_XOR   = 4'h3,
    ALU_ADD   = 4'h4,
    ALU_SUB   = 4'h5,
    ALU_SHR   = 4'h6,
    ALU_SUBN  = 4'h7,
    ALU_SHL   = 4'hE
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
  } alu_rsp_t;

endpackage

>>> hdl/c8_in_if.sv
`timescale 1ns / 1ps
interface c8_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] address;
  logic [7:0]  data;
  logic [15:0] key_mask;
  logic [7:0]  random_byte;

  modport source (output valid, operation, address, data, key_mask, random_byte,
                  input ready);
  modport sink (input valid, operation, address, data, key_mask, random_byte,
                output ready);
endinterface

>>> hdl/c8_out_if.sv
`timescale 1ns / 1ps
interface c8_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [11:0] pc_now;
  logic        sound_on;
  logic [1:0]  status;

  modport source (output valid, read_data, pc_now, sound_on, status, input ready);
  modport sink (input valid, read_data, pc_now, sound_on, status, output ready);
endinterface

>>> hdl/c8_ram.sv
`timescale 1ns / 1ps
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/c8_alu.sv
`timescale 1ns / 1ps
module c8_alu (
  input  c8_pkg::alu_req_t req,
  output c8_pkg::alu_rsp_t rsp
);
  import c8_pkg::*;

  logic [8:0] sum;

  always_comb begin
    sum = {1'b0, req.a} + {1'b0, req.b};
    rsp = '0;
    case (req.op)
      ALU_PASSB: rsp.res = req.b;
      ALU_OR:    rsp.res = req.a | req.b;
      ALU_AND:   rsp.res = req.a & req.b;
      ALU_XOR:   rsp.res = req.a ^ req.b;
      ALU_ADD: begin
        rsp.res  = sum[7:0];
        rsp.flag = sum[8];
      end
      ALU_SUB: begin
        rsp.res  = req.a - req.b;
        rsp.flag = (req.a >= req.b);
      end
      ALU_SUBN: begin
        rsp.res  = req.b - req.a;
        rsp.flag = (req.b >= req.a);
      end
      ALU_SHR: begin
        rsp.res  = {1'b0, req.a[7:1]};
        rsp.flag = req.a[0];
      end
      ALU_SHL: begin
        rsp.res  = {req.a[6:0], 1'b0};
        rsp.flag = req.a[7];
      end
      default: rsp.res = req.b;
    endcase
  end
endmodule

>>> hdl/chip8_instruction_core_unit.sv
`timescale 1ns / 1ps
// CHIP-8 instruction core.
// in_chan (valid/ready) carries one transaction per item: write a memory byte,
// execute one instruction, tick the delay/sound timers, or read a pixel.
// out_chan returns exactly one transaction per item: pixel (read items only),
// program counter, sound flag and status.
// cfg_we/cfg_wdata load the PC directly.
// A pixel read beyond the frame (address bit 11 set) skips the frame read.
// Instructions that write VF do so in an extra step, S_VF. A sprite draw
// fetches each row, steps through its pixels and writes back each set pixel;
// Fx55 and Fx65 move one register at a time, and 00E0 sweeps the whole frame
// to clear it. One item is worked at a time through the single shared ALU and
// the memories, each with one write and one read port; in_chan.ready is high
// only while idle, so the next item can be taken as soon as a result is offered.
// Reset runs a pass that loads the font and clears memory and frame; no item
// is taken meanwhile, configuration writes are.
// A finished result waits in the output register while the next item is taken;
// if the receiver still stalls, the core holds in its final step.
module chip8_instruction_core_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  c8_in_if.sink       in_chan,
  c8_out_if.source    out_chan,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata
);
  import c8_pkg::*;

  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W = $clog2(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MWR, S_PRD, S_PRDW, S_F1, S_F2, S_F3, S_RX, S_RY, S_EXEC,
    S_VF, S_FCLR, S_DRD, S_DROW, S_DPIX, S_DWR, S_BCD, S_STR, S_LDR, S_LDW, S_DONE
  } state_t;

  state_t      state_r;
  logic [11:0] pc_r, cnt_r, addr_r;
  logic [15:0] idx_r, inst_r, keys_r;
  logic [SP_W-1:0] sp_r, spm1;
  logic [11:0] stack_r [STACK_DEPTH];
  logic [7:0]  regs_r [16];
  logic [7:0]  delay_r, sound_r, data_r, rnd_r, vx_r, vy_r, row_r;
  logic        flag_r, rd_r;
  status_t     st_r;
  logic [3:0]  rcnt_r;
  logic [2:0]  col_r;
  logic        out_valid_r, out_sound_r;
  logic [7:0]  out_rd_r;
  logic [11:0] out_pc_r;
  status_t     out_st_r;

  logic [3:0]  gx, gy, gn, grp;
  logic [7:0]  kk;
  logic [11:0] nnn, pc_next, pc_skip;
  logic [3:0]  rf_ra;
  logic [7:0]  rf_rd;
  logic        mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd, mem_rd;
  logic        fr_we, fr_wd, fr_rd;
  logic [FR_AW-1:0] fr_wa, fr_ra, kaddr;
  logic [4:0]  py;
  logic [5:0]  px;
  logic [13:0] h_prod;
  logic [15:0] t_prod;
  logic [7:0]  bcd_h, bcd_q, bcd_t, bcd_o, bcd_d;
  logic [6:0]  font_i;
  logic        eq, key_hit, done_go;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  assign gx      = inst_r[11:8];
  assign gy      = inst_r[7:4];
  assign gn      = inst_r[3:0];
  assign grp     = inst_r[15:12];
  assign kk      = inst_r[7:0];
  assign nnn     = inst_r[11:0];
  assign pc_next = pc_r + 12'd2;
  assign pc_skip = pc_r + 12'd4;
  assign spm1    = sp_r - SP_W'(1);
  assign rf_rd   = regs_r[rf_ra];
  assign eq      = (alu_rsp.res == 8'd0);
  assign key_hit = keys_r[vx_r[3:0]];
  assign py      = vy_r[4:0] + {1'b0, rcnt_r};
  assign px      = vx_r[5:0] + {3'b000, col_r};
  assign kaddr   = {py, px};
  assign font_i  = 7'(cnt_r - FONT_BASE);
  assign done_go = !out_valid_r || out_chan.ready;

  // decimal digits by reciprocal multiply
  always_comb begin
    h_prod = {6'd0, vx_r} * 14'd41;
    t_prod = {8'd0, vx_r} * 16'd205;
    bcd_h  = {6'd0, h_prod[13:12]};
    bcd_q  = {3'd0, t_prod[15:11]};
    bcd_t  = bcd_q - 8'(bcd_h * 8'd10);
    bcd_o  = vx_r - 8'(bcd_q * 8'd10);
    case (cnt_r[1:0])
      2'd0:    bcd_d = bcd_h;
      2'd1:    bcd_d = bcd_t;
      default: bcd_d = bcd_o;
    endcase
  end

  c8_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
    .raddr(mem_ra), .rdata(mem_rd)
  );

  c8_ram #(.WIDTH(1), .DEPTH(FRAME_W * FRAME_H)) u_frame (
    .clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd),
    .raddr(fr_ra), .rdata(fr_rd)
  );

  always_comb begin
    alu_req = '{op: ALU_PASSB, a: vx_r, b: kk};
    if (state_r == S_EXEC) begin
      case (grp)
        OPG_SE, OPG_SNE: alu_req.op = ALU_XOR;
        OPG_SEV, OPG_SNEV: begin
          alu_req.op = ALU_XOR;
          alu_req.b  = vy_r;
        end
        OPG_ADD: alu_req.op = ALU_ADD;
        OPG_ALU: begin
          alu_req.op = alu_op_t'(gn);
          alu_req.b  = vy_r;
        end
        OPG_RND: begin
          alu_req.op = ALU_AND;
          alu_req.a  = rnd_r;
        end
        default: alu_req.op = ALU_PASSB;
      endcase
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r[11:0];
    mem_wd = 8'd0;
    mem_ra = pc_r;
    fr_we  = 1'b0;
    fr_wa  = kaddr;
    fr_wd  = 1'b0;
    fr_ra  = kaddr;
    rf_ra  = gx;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        mem_wd = (cnt_r inside {[FONT_BASE:FONT_END]}) ? FONT_ROM[font_i] : 8'd0;
        fr_we  = 1'b1;
        fr_wa  = cnt_r[FR_AW-1:0];
      end
      S_FCLR: begin
        fr_we = 1'b1;
        fr_wa = cnt_r[FR_AW-1:0];
      end
      S_MWR: begin
        mem_we = 1'b1;
        mem_wa = addr_r;
        mem_wd = data_r;
      end
      S_PRD:  fr_ra = addr_r[FR_AW-1:0];
      S_F2:   mem_ra = pc_r + 12'd1;
      S_RY:   rf_ra = gy;
      S_DRD:  mem_ra = idx_r[11:0] + {8'd0, rcnt_r};
      S_DWR: begin
        fr_we = 1'b1;
        fr_wd = ~fr_rd;
      end
      S_BCD: begin
        mem_we = 1'b1;
        mem_wa = idx_r[11:0] + {10'd0, cnt_r[1:0]};
        mem_wd = bcd_d;
      end
      S_STR: begin
        rf_ra  = cnt_r[3:0];
        mem_we = 1'b1;
        mem_wa = idx_r[11:0] + {8'd0, cnt_r[3:0]};
        mem_wd = rf_rd;
      end
      S_LDR:  mem_ra = idx_r[11:0] + {8'd0, cnt_r[3:0]};
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pc_r        <= RESET_START;
      idx_r       <= '0;
      sp_r        <= '0;
      delay_r     <= '0;
      sound_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 12'd1;
          if (cnt_r == 12'hFFF) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            addr_r <= in_chan.address;
            data_r <= in_chan.data;
            keys_r <= in_chan.key_mask;
            rnd_r  <= in_chan.random_byte;
            rd_r   <= 1'b0;
            st_r   <= STAT_OK;
            case (item_op_t'(in_chan.operation))
              ITEM_WRITE: state_r <= S_MWR;
              ITEM_EXEC:  state_r <= S_F1;
              ITEM_TICK: begin
                if (delay_r != 8'd0) delay_r <= delay_r - 8'd1;
                if (sound_r != 8'd0) sound_r <= sound_r - 8'd1;
                state_r <= S_DONE;
              end
              default: state_r <= in_chan.address[11] ? S_DONE : S_PRD;
            endcase
          end
        end
        S_MWR:  state_r <= S_DONE;
        S_PRD:  state_r <= S_PRDW;
        S_PRDW: begin
          rd_r    <= fr_rd;
          state_r <= S_DONE;
        end
        S_F1:   state_r <= S_F2;
        S_F2: begin
          inst_r[15:8] <= mem_rd;
          state_r      <= S_F3;
        end
        S_F3: begin
          inst_r[7:0] <= mem_rd;
          state_r     <= S_RX;
        end
        S_RX: begin
          vx_r    <= rf_rd;
          state_r <= S_RY;
        end
        S_RY: begin
          vy_r    <= rf_rd;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          pc_r    <= pc_next;
          state_r <= S_DONE;
          case (grp)
            OPG_SYS: begin
              if (nnn == SYS_CLS) begin
                cnt_r   <= '0;
                state_r <= S_FCLR;
              end else if (nnn == SYS_RET) begin
                if (sp_r == '0) begin
                  st_r <= STAT_UNF;
                end else begin
                  sp_r <= spm1;
                  pc_r <= stack_r[spm1[SIDX_W-1:0]];
                end
              end else begin
                st_r <= STAT_BADOP;
              end
            end
            OPG_JP: pc_r <= nnn;
            OPG_CALL: begin
              if (sp_r == SP_W'(STACK_DEPTH)) begin
                st_r <= STAT_OVF;
              end else begin
                stack_r[sp_r[SIDX_W-1:0]] <= pc_next;
                sp_r <= sp_r + SP_W'(1);
                pc_r <= nnn;
              end
            end
            OPG_SE:  if (eq) pc_r <= pc_skip;
            OPG_SNE: if (!eq) pc_r <= pc_skip;
            OPG_SEV, OPG_SNEV: begin
              if (gn != 4'd0) begin
                st_r <= STAT_BADOP;
              end else if (eq == (grp == OPG_SEV)) begin
                pc_r <= pc_skip;
              end
            end
            OPG_LD, OPG_ADD, OPG_RND: regs_r[gx] <= alu_rsp.res;
            OPG_ALU: begin
              if (gn inside {ALU_PASSB, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                             ALU_SHR, ALU_SUBN, ALU_SHL}) begin
                regs_r[gx] <= alu_rsp.res;
                flag_r     <= alu_rsp.flag;
                if (gn inside {ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL}) begin
                  state_r <= S_VF;
                end
              end else begin
                st_r <= STAT_BADOP;
              end
            end
            OPG_LDI: idx_r <= {4'd0, nnn};
            OPG_JPV: pc_r <= nnn + {4'd0, regs_r[0]};
            OPG_DRW: begin
              flag_r  <= 1'b0;
              rcnt_r  <= '0;
              col_r   <= '0;
              state_r <= (gn == 4'd0) ? S_VF : S_DRD;
            end
            OPG_KEY: begin
              if (kk == KEY_SKP) begin
                if (key_hit) pc_r <= pc_skip;
              end else if (kk == KEY_SKNP) begin
                if (!key_hit) pc_r <= pc_skip;
              end else begin
                st_r <= STAT_BADOP;
              end
            end
            default: begin
              cnt_r <= '0;
              case (kk)
                FX_LDDT:  regs_r[gx] <= delay_r;
                FX_WAITK: state_r <= S_DONE;
                FX_SETDT: delay_r <= vx_r;
                FX_SETST: sound_r <= vx_r;
                FX_ADDI:  idx_r <= idx_r + {8'd0, vx_r};
                FX_FONT:  idx_r <= {4'd0, FONT_BASE} + {10'd0, vx_r[3:0], 2'b00}
                                   + {12'd0, vx_r[3:0]};
                FX_BCD:   state_r <= S_BCD;
                FX_STORE: state_r <= S_STR;
                FX_LOAD:  state_r <= S_LDR;
                default:  st_r <= STAT_BADOP;
              endcase
            end
          endcase
        end
        S_VF: begin
          regs_r[15] <= {7'd0, flag_r};
          state_r    <= S_DONE;
        end
        S_FCLR: begin
          cnt_r <= cnt_r + 12'd1;
          if (cnt_r[FR_AW-1:0] == '1) begin
            state_r <= S_DONE;
          end
        end
        S_DRD:  state_r <= S_DROW;
        S_DROW: begin
          row_r   <= mem_rd;
          col_r   <= '0;
          state_r <= S_DPIX;
        end
        S_DPIX, S_DWR: begin
          if (state_r == S_DPIX && row_r[3'd7 - col_r]) begin
            state_r <= S_DWR;
          end else begin
            if (state_r == S_DWR && fr_rd) flag_r <= 1'b1;
            // advance to next pixel or row
            if (col_r == 3'd7) begin
              col_r <= '0;
              if (rcnt_r == gn - 4'd1) begin
                state_r <= S_VF;
              end else begin
                rcnt_r  <= rcnt_r + 4'd1;
                state_r <= S_DRD;
              end
            end else begin
              col_r   <= col_r + 3'd1;
              state_r <= S_DPIX;
            end
          end
        end
        S_BCD: begin
          cnt_r <= cnt_r + 12'd1;
          if (cnt_r[1:0] == 2'd2) state_r <= S_DONE;
        end
        S_STR: begin
          cnt_r <= cnt_r + 12'd1;
          if (cnt_r[3:0] == gx) state_r <= S_DONE;
        end
        S_LDR: state_r <= S_LDW;
        S_LDW: begin
          regs_r[cnt_r[3:0]] <= mem_rd;
          cnt_r <= cnt_r + 12'd1;
          state_r <= (cnt_r[3:0] == gx) ? S_DONE : S_LDR;
        end
        S_DONE: begin
          if (done_go) begin
            out_valid_r <= 1'b1;
            out_rd_r    <= {7'd0, rd_r};
            out_pc_r    <= pc_r;
            out_sound_r <= (sound_r != 8'd0);
            out_st_r    <= st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
    end
  end

  assign in_chan.ready      = (state_r == S_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_rd_r;
  assign out_chan.pc_now    = out_pc_r;
  assign out_chan.sound_on  = out_sound_r;
  assign out_chan.status    = out_st_r;

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("second item taken while busy");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside final step");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.read_data[7:1] == 7'd0)
    else $error("pixel read wider than one bit");
`endif
endmodule
